>>> rtl/stt_pkg.sv
// Shared types and codes for the software timer table.
package stt_pkg;
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_STOP = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_FIRE = 2'd0,
    KIND_SET  = 2'd1,
    KIND_STOP = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  id;
    logic [63:0] now;
    logic [63:0] due;
    logic [63:0] per;
    logic [7:0]  q;
    logic [31:0] msg;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [7:0]  q;
    logic [31:0] msg;
    logic        acc;
    logic        last;
  } res_t;
endpackage

>>> rtl/stt_front.sv
// Front end: accepts requests, drops operation 3 (OP_NONE), precomputes the set deadline.
module stt_front
  import stt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_timer_id,
  input  logic [63:0] in_now_time,
  input  logic [63:0] in_countdown,
  input  logic [63:0] in_period,
  input  logic [7:0]  in_target_queue,
  input  logic [31:0] in_message,
  output logic        req_valid,
  output req_t        req,
  input  logic        req_ready
);
  logic valid_r;
  req_t req_r;

  assign in_full   = valid_r && !req_ready;
  assign req_valid = valid_r;
  assign req       = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_push && !in_full) begin
      valid_r <= (in_operation != OP_NONE);
    end else if (req_ready) begin
      valid_r <= 1'b0;
    end
    if (in_push && !in_full) begin
      req_r.op  <= in_operation;
      req_r.id  <= in_timer_id;
      req_r.now <= in_now_time;
      req_r.due <= in_now_time + in_countdown;
      req_r.per <= in_period;
      req_r.q   <= in_target_queue;
      req_r.msg <= in_message;
    end
  end
endmodule

>>> rtl/stt_queue.sv
// Two-entry request queue between the front end and the list engine.
module stt_queue
  import stt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  input  req_t wr_data,
  output logic wr_ready,
  output logic rd_valid,
  output req_t rd_data,
  input  logic rd_ready
);
  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

>>> rtl/stt_engine.sv
// List engine: holds the timer list, runs search, set, stop and the tick walk.
module stt_engine
  import stt_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  input  req_t req,
  output logic req_ready,
  output logic res_valid,
  output res_t res,
  input  logic res_ready
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EVAL, S_EXEC, S_MOVE, S_COPY, S_FLUSH
  } state_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [63:0] due;
    logic [63:0] per;
    logic [7:0]  q;
    logic [31:0] msg;
  } ent_t;

  ent_t mem [SLOTS];

  state_t        state_r, state_nxt;
  req_t          cur_r, cur_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  res_t          res_r, res_nxt;
  logic          rvalid_r, rvalid_nxt;
  res_t          pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;
  ent_t          rd_r;
  logic          rd_en;
  logic          we;
  logic [IW-1:0] waddr, raddr;
  ent_t          wdata;
  logic [CW-1:0] idx_inc, cnt_dec;
  logic          out_free, fire, scan_end, set_ok;

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = rvalid_r;
  assign res       = res_r;
  assign idx_inc   = idx_r + CW'(1);
  assign cnt_dec   = cnt_r - CW'(1);
  assign scan_end  = (idx_inc >= cnt_r);
  assign out_free  = !rvalid_r || res_ready;
  assign set_ok    = found_r || (cnt_r < CW'(SLOTS));
  assign fire      = (rd_r.due != 64'd0) && (cur_r.now >= rd_r.due);
  // read the last entry while moving it into a hole, else the walk position
  assign raddr     = (state_r == S_MOVE) ? cnt_r[IW-1:0] : idx_r[IW-1:0];
  assign rd_en     = (state_r == S_READ) || (state_r == S_MOVE);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rd_r <= mem[raddr];
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    res_nxt    = res_r;
    rvalid_nxt = rvalid_r && !res_ready;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    we         = 1'b0;
    waddr      = idx_r[IW-1:0];
    wdata      = rd_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          cur_nxt    = req;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          pend_v_nxt = 1'b0;
          if (cnt_r != '0) state_nxt = S_READ;
          else if (req.op != OP_TICK) state_nxt = S_EXEC;
        end
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        if (cur_r.op != OP_TICK) begin
          if (rd_r.id == cur_r.id) begin
            found_nxt = 1'b1;
            state_nxt = S_EXEC;
          end else if (scan_end) begin
            state_nxt = S_EXEC;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_READ;
          end
        end else if (!fire) begin
          idx_nxt   = idx_inc;
          state_nxt = scan_end ? S_FLUSH : S_READ;
        end else if (!pend_v_r || out_free) begin
          // release the previous expiry, hold this one until last is known
          if (pend_v_r) begin
            res_nxt    = pend_r;
            rvalid_nxt = 1'b1;
          end
          pend_nxt = '{kind: KIND_FIRE, id: rd_r.id, q: rd_r.q, msg: rd_r.msg,
                       acc: 1'b0, last: 1'b0};
          pend_v_nxt = 1'b1;
          if (rd_r.per != 64'd0) begin
            we        = 1'b1;
            wdata.due = cur_r.now + rd_r.per;
            idx_nxt   = idx_inc;
            state_nxt = scan_end ? S_FLUSH : S_READ;
          end else begin
            cnt_nxt   = cnt_dec;
            state_nxt = scan_end ? S_FLUSH : S_MOVE;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          rvalid_nxt = 1'b1;
          if (cur_r.op == OP_SET) begin
            res_nxt = '{kind: KIND_SET, id: cur_r.id, q: 8'd0, msg: 32'd0,
                        acc: set_ok, last: 1'b1};
            if (set_ok) begin
              we    = 1'b1;
              waddr = found_r ? idx_r[IW-1:0] : cnt_r[IW-1:0];
              wdata = '{id: cur_r.id, due: cur_r.due, per: cur_r.per,
                        q: cur_r.q, msg: cur_r.msg};
            end
            if (!found_r && set_ok) cnt_nxt = cnt_r + CW'(1);
            state_nxt = S_IDLE;
          end else begin
            res_nxt = '{kind: KIND_STOP, id: cur_r.id, q: 8'd0, msg: 32'd0,
                        acc: 1'b0, last: 1'b1};
            if (found_r) begin
              cnt_nxt   = cnt_dec;
              state_nxt = scan_end ? S_IDLE : S_MOVE;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_MOVE: state_nxt = S_COPY;
      S_COPY: begin
        // fill the hole; a tick checks the moved entry next from rd_r
        we        = 1'b1;
        state_nxt = (cur_r.op == OP_TICK) ? S_EVAL : S_IDLE;
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          res_nxt      = pend_r;
          res_nxt.last = 1'b1;
          rvalid_nxt   = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      rvalid_r <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rvalid_r <= rvalid_nxt;
      pend_v_r <= pend_v_nxt;
    end
    cur_r   <= cur_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    res_r   <= res_nxt;
    pend_r  <= pend_nxt;
  end
endmodule

>>> rtl/software_timer_table.sv
// Top level of the software timer table.
// Requests pass an input register and a two-deep queue to reach the list engine;
// the engine runs them one at a time, and operation 3 is dropped at the input. Set
// and stop scan the list entry by entry. A tick walks the list, and each one-shot
// expiry pulls the last entry into its slot. A waiting result that is not popped
// stalls the engine. The list memory has a single read port. No clearing pass is
// needed after reset.
module software_timer_table
  import stt_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_timer_id,
  input  logic [63:0] in_now_time,
  input  logic [63:0] in_countdown,
  input  logic [63:0] in_period,
  input  logic [7:0]  in_target_queue,
  input  logic [31:0] in_message,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_fired_id,
  output logic [7:0]  out_dest_queue,
  output logic [31:0] out_payload,
  output logic        out_accepted,
  output logic        out_last
);
  logic f_valid, f_ready, e_valid, e_ready, r_valid;
  req_t f_req, e_req;
  res_t r;

  stt_front u_front (
    .clk, .rst_n, .in_push(push), .in_full(full),
    .in_operation, .in_timer_id, .in_now_time, .in_countdown, .in_period,
    .in_target_queue, .in_message,
    .req_valid(f_valid), .req(f_req), .req_ready(f_ready)
  );

  stt_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_data(f_req), .wr_ready(f_ready),
    .rd_valid(e_valid), .rd_data(e_req), .rd_ready(e_ready)
  );

  stt_engine #(.SLOTS(SLOTS)) u_engine (
    .clk, .rst_n, .req_valid(e_valid), .req(e_req), .req_ready(e_ready),
    .res_valid(r_valid), .res(r), .res_ready(pop)
  );

  assign empty          = !r_valid;
  assign out_kind       = r.kind;
  assign out_fired_id   = r.id;
  assign out_dest_queue = r.q;
  assign out_payload    = r.msg;
  assign out_accepted   = r.acc;
  assign out_last       = r.last;
endmodule

>>> rtl/stt_checker.sv
// Port checker for the software timer table, bound to the top level.
module stt_checker
  import stt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [1:0] out_kind,
  input logic [7:0] out_dest_queue,
  input logic       out_accepted,
  input logic       out_last
);
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != KIND_FIRE) |-> out_last)
    else $error("acknowledge without last");
  a_ack_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != KIND_FIRE) |-> (out_dest_queue == 8'd0))
    else $error("acknowledge carries a queue");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != KIND_SET) |-> !out_accepted)
    else $error("accepted outside set acknowledge");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("result dropped");
endmodule

bind software_timer_table stt_checker u_chk (
  .clk, .rst_n, .empty, .pop, .out_kind, .out_dest_queue, .out_accepted, .out_last
);
